[sv/jesc_pkg.sv]
// Shared types and constants for the JSON escape subset checker.
// Depends on nothing; used by the byte classifier and the top level.

package jesc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned DIGIT_W = 3;
   localparam int unsigned NIBBLE_W = 4;

   localparam logic [UNIT_W-1:0] HIGH_SURR_LO = 16'hd800;
   localparam logic [UNIT_W-1:0] HIGH_SURR_HI = 16'hdbff;
   localparam logic [UNIT_W-1:0] LOW_SURR_LO  = 16'hdc00;
   localparam logic [UNIT_W-1:0] LOW_SURR_HI  = 16'hdfff;
   localparam logic [UNIT_W-1:0] NUL_UNIT     = 16'h0000;

   localparam logic [DIGIT_W-1:0] UNIT_DIGITS = 3'd4;

   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
   localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3a;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;

   // Byte classes seen by the scanner
   typedef struct packed {
      logic                is_quote;
      logic                is_bslash;
      logic                is_u;
      logic                is_ws;
      logic                is_colon;
      logic                is_hex;
      logic [NIBBLE_W-1:0] hex_val;
   } byte_class_type;

endpackage

[sv/jesc_classify.sv]
// Byte classifier: decodes one text byte into the classes the scanner needs.
// Depends on jesc_pkg.

module jesc_classify
   import jesc_pkg::*;
(
   input  logic [BYTE_W-1:0] text_byte,
   output byte_class_type    byte_class
);

   always_comb begin
      byte_class           = '0;
      byte_class.is_quote  = (text_byte == CH_QUOTE);
      byte_class.is_bslash = (text_byte == CH_BSLASH);
      byte_class.is_u      = (text_byte == CH_U);
      byte_class.is_colon  = (text_byte == CH_COLON);
      byte_class.is_ws     = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                             (text_byte == CH_CR) || (text_byte == CH_LF);
      // '0'..'9', 'a'..'f', 'A'..'F'
      if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
         byte_class.is_hex  = 1'b1;
         byte_class.hex_val = text_byte[NIBBLE_W-1:0];
      end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
         byte_class.is_hex  = 1'b1;
         byte_class.hex_val = text_byte[NIBBLE_W-1:0] + 4'd9;
      end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
         byte_class.is_hex  = 1'b1;
         byte_class.hex_val = text_byte[NIBBLE_W-1:0] + 4'd9;
      end
   end

endmodule

[sv/json_escape_subset_checker.sv]
// JSON escape subset checker: one byte per item, verdict on the final byte.
// A final byte's verdict is registered on rsp_, or in the skid slot if rsp_ stalls.
// Throughput: one byte per cycle unless req_stall; scan state updates on acceptance.
// Output register plus one skid slot: req_stall rises only when both are full.
// Reset (synchronous, active high) returns the scanner to outside any string
// and empties the result register and skid slot. Depends on jesc_pkg, jesc_classify.

module json_escape_subset_checker
   import jesc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_text_byte,
   input  logic              req_final_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_text_ok
);

   // Scanner modes
   typedef enum logic [3:0] {
      MODE_OUT      = 4'd0,  // outside any string
      MODE_STR      = 4'd1,  // string body
      MODE_ESC      = 4'd2,  // after a backslash
      MODE_HEX      = 4'd3,  // first \u digits
      MODE_PAIR_BS  = 4'd4,  // high surrogate done, backslash must follow
      MODE_PAIR_U   = 4'd5,  // 'u' must follow
      MODE_PAIR_HEX = 4'd6,  // low surrogate digits
      MODE_AFTER    = 4'd7   // closing quote of a NUL string, colon watch
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [UNIT_W-1:0]    code_unit;
      logic [DIGIT_W-1:0]   digits_seen;
      logic                 saw_nul;
      logic                 rejected;
   } scan_state_type;

   typedef struct packed {
      scan_state_type state;
      logic           again;   // byte must be run through once more
   } pass_type;

   byte_class_type byte_class;

   scan_state_type scan_ff, scan_in;
   pass_type       pass_one, pass_two;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_ok_ff, skid_ok_in;

   logic req_take, rsp_pop, verdict;

   // One pass of the scanner over one byte
   function automatic pass_type scan_pass(scan_state_type cur, byte_class_type bc);
      pass_type           res;
      logic [UNIT_W-1:0]  unit;
      logic [DIGIT_W-1:0] cnt;
      res       = '0;
      res.state = cur;
      unit      = {cur.code_unit[UNIT_W-NIBBLE_W-1:0], bc.hex_val};
      cnt       = cur.digits_seen + 3'd1;
      case (cur.mode)
         MODE_STR: begin
            if (bc.is_bslash) begin
               res.state.mode = MODE_ESC;
            end else if (bc.is_quote) begin
               res.state.mode = cur.saw_nul ? MODE_AFTER : MODE_OUT;
            end
         end
         MODE_ESC: begin
            if (bc.is_u) begin
               res.state.mode        = MODE_HEX;
               res.state.code_unit   = '0;
               res.state.digits_seen = '0;
            end else begin
               res.state.mode = MODE_STR;
            end
         end
         MODE_HEX: begin
            if (!bc.is_hex) begin
               // escape abandoned, byte is string content
               res.state.mode = MODE_STR;
               res.again      = 1'b1;
            end else begin
               res.state.code_unit   = unit;
               res.state.digits_seen = cnt;
               if (cnt >= UNIT_DIGITS) begin
                  if (unit == NUL_UNIT) res.state.saw_nul = 1'b1;
                  if (unit >= HIGH_SURR_LO && unit <= HIGH_SURR_HI) begin
                     res.state.mode = MODE_PAIR_BS;
                  end else begin
                     if (unit >= LOW_SURR_LO && unit <= LOW_SURR_HI)
                        res.state.rejected = 1'b1;
                     res.state.mode = MODE_STR;
                  end
               end
            end
         end
         MODE_PAIR_BS: begin
            if (bc.is_bslash) begin
               res.state.mode = MODE_PAIR_U;
            end else begin
               res.state.rejected = 1'b1;
               res.state.mode     = MODE_STR;
               res.again          = 1'b1;
            end
         end
         MODE_PAIR_U: begin
            if (bc.is_u) begin
               res.state.mode        = MODE_PAIR_HEX;
               res.state.code_unit   = '0;
               res.state.digits_seen = '0;
            end else begin
               res.state.rejected = 1'b1;
               res.state.mode     = MODE_STR;
            end
         end
         MODE_PAIR_HEX: begin
            if (!bc.is_hex) begin
               res.state.rejected = 1'b1;
               res.state.mode     = MODE_STR;
               res.again          = 1'b1;
            end else begin
               res.state.code_unit   = unit;
               res.state.digits_seen = cnt;
               if (cnt >= UNIT_DIGITS) begin
                  if (unit < LOW_SURR_LO || unit > LOW_SURR_HI)
                     res.state.rejected = 1'b1;
                  res.state.mode = MODE_STR;
               end
            end
         end
         MODE_AFTER: begin
            if (bc.is_ws) begin
               res.state.mode = MODE_AFTER;
            end else if (bc.is_colon) begin
               // NUL string used as a key
               res.state.rejected = 1'b1;
               res.state.mode     = MODE_OUT;
            end else begin
               res.state.mode = MODE_OUT;
               res.again      = 1'b1;
            end
         end
         default: begin
            // outside a string; unused codes land here too
            if (bc.is_quote) begin
               res.state.mode    = MODE_STR;
               res.state.saw_nul = 1'b0;
            end else begin
               res.state.mode = MODE_OUT;
            end
         end
      endcase
      return res;
   endfunction

   jesc_classify u_classify (
      .text_byte  (req_text_byte),
      .byte_class (byte_class)
   );

   // Handshakes: only a full skid slot holds off the input side
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_pop   = rsp_valid_ff && !rsp_stall;

   // A byte can need a second pass (abandoned escape, broken pair, byte after NUL string)
   always_comb begin
      pass_one = scan_pass(scan_ff, byte_class);
      pass_two = scan_pass(pass_one.state, byte_class);
   end

   // Verdict on the state after this byte, before the end-of-text clear
   always_comb begin
      scan_state_type after_byte;
      after_byte = pass_one.again ? pass_two.state : pass_one.state;
      verdict    = !after_byte.rejected &&
                   (after_byte.mode != MODE_PAIR_BS) &&
                   (after_byte.mode != MODE_PAIR_U) &&
                   (after_byte.mode != MODE_PAIR_HEX);
      scan_in = scan_ff;
      if (req_take) begin
         if (req_final_byte) begin
            scan_in      = '0;
            scan_in.mode = MODE_OUT;
         end else begin
            scan_in = after_byte;
         end
      end
   end

   // Result register with one skid slot behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      skid_valid_in = skid_valid_ff;
      skid_ok_in    = skid_ok_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_ok_in     = skid_ok_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take && req_final_byte) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = verdict;
         end else begin
            skid_valid_in = 1'b1;
            skid_ok_in    = verdict;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         scan_ff       <= scan_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_ok_ff  <= rsp_ok_in;
      skid_ok_ff <= skid_ok_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_text_ok = rsp_ok_ff;

endmodule

[sv/jesc_checker.sv]
// Port-level checker for the JSON escape subset checker, bound to the top level.
// Depends on json_escape_subset_checker.

module jesc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_final_byte,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_text_ok
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_text_ok)))
      else $error("stalled result changed");

   // input side is only held off while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   // final byte into an empty output gives a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_final_byte && !rsp_valid) |=> rsp_valid)
      else $error("final item produced no result");

   // a non-final byte into an empty output gives no result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_final_byte && !rsp_valid) |=> !rsp_valid)
      else $error("result without a final item");

   // nothing pending straight after reset
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result or stall after reset");

endmodule

bind json_escape_subset_checker jesc_checker u_jesc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_final_byte (req_final_byte),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_text_ok    (rsp_text_ok)
);
